FILE: hdl/gncm_pkg.sv
`timescale 1ns / 1ps
// ============================================================================
// gncm_pkg: shared types and constants of the grid neighbour count marker
// Holds the field widths, configuration register indexes, reset values and
// the job record that travels from the front end through the queue to the
// back end.
// ============================================================================
package gncm_pkg;

    // Internal width for frame dimensions and row positions. It holds the
    // largest row position, which is the frame height plus two.
    localparam int DIM_W     = 10;
    localparam int CFG_W     = 9;
    localparam int LIMIT_W   = 4;
    localparam int COUNT_W   = 4;
    localparam int TOTAL_W   = 17;
    localparam int WINDOW_W  = 9;
    localparam int CFG_IDX_W = 2;

    localparam logic [TOTAL_W-1:0] TOTAL_MAX = '1;

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] CFG_FRAME_WIDTH     = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_FRAME_HEIGHT    = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_NEIGHBOUR_LIMIT = 2'd2;

    // Register reset values.
    localparam logic [CFG_W-1:0]   FRAME_WIDTH_RESET     = 9'd256;
    localparam logic [CFG_W-1:0]   FRAME_HEIGHT_RESET    = 9'd256;
    localparam logic [LIMIT_W-1:0] NEIGHBOUR_LIMIT_RESET = 4'd4;

    // Queue between the front end and the back end.
    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_W      = 2;
    localparam int QCNT_W      = 3;

    // Window geometry: column k occupies bits 3k..3k+2, row j sits at bit
    // 3k+j. Column 2 is the newest, row 0 is the upper line.
    localparam int CENTRE_BIT = 4;

    typedef struct packed {
        logic has_result;   // the reported cell lies inside the frame
        logic clear_total;  // frame start: clear the running total
        logic col_first;    // reported cell is in the leftmost column
        logic col_last;     // reported cell is in the rightmost column
        logic row_first;    // reported cell is in the top row
        logic row_last;     // reported cell is in the bottom row
        logic last_cell;    // reported cell is the frame's last
    } job_flags_t;

    typedef struct packed {
        logic [WINDOW_W-1:0] window;
        job_flags_t          flags;
    } job_t;

endpackage

FILE: hdl/gncm_front.sv
`timescale 1ns / 1ps
// ============================================================================
// gncm_front: position tracking, line stores and window
// Accepts cells, tracks column and row, reads and updates the two line
// stores, shifts the 3x3 window and classifies each cell into a job for the
// back end.
// ============================================================================
module gncm_front #(
    parameter int MAX_WIDTH  = 256,
    parameter int MAX_HEIGHT = 256
) (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      in_valid,
    output logic                      in_ready,
    input  logic                      action,
    input  logic                      occupied,
    input  logic                      frame_start,
    input  logic [gncm_pkg::CFG_W-1:0] frame_width,
    input  logic [gncm_pkg::CFG_W-1:0] frame_height,
    output logic                      job_valid,
    output gncm_pkg::job_t            job,
    input  logic                      queue_full
);

    localparam int CFG_MAX    = (2 ** gncm_pkg::CFG_W) - 1;
    localparam int W_CAP      = (MAX_WIDTH < CFG_MAX) ? MAX_WIDTH : CFG_MAX;
    localparam int H_CAP      = (MAX_HEIGHT < CFG_MAX) ? MAX_HEIGHT : CFG_MAX;
    localparam int LA_W       = $clog2(W_CAP);
    localparam int LINE_DEPTH = W_CAP;

    localparam logic [gncm_pkg::DIM_W-1:0] W_CAP_V = gncm_pkg::DIM_W'(W_CAP);
    localparam logic [gncm_pkg::DIM_W-1:0] H_CAP_V = gncm_pkg::DIM_W'(H_CAP);
    localparam logic [gncm_pkg::DIM_W-1:0] DIM_ONE = gncm_pkg::DIM_W'(1);
    localparam logic [gncm_pkg::DIM_W-1:0] DIM_TWO = gncm_pkg::DIM_W'(2);

    logic [gncm_pkg::DIM_W-1:0] w_eff;
    logic [gncm_pkg::DIM_W-1:0] h_eff;
    logic [gncm_pkg::DIM_W-1:0] h_p1;
    logic [gncm_pkg::DIM_W-1:0] h_p2;

    // Position state.
    logic [LA_W-1:0]            col_reg;
    logic [LA_W-1:0]            col_next;
    logic [gncm_pkg::DIM_W-1:0] row_reg;
    logic [gncm_pkg::DIM_W-1:0] row_next;

    // Input stage view of the position.
    logic [LA_W-1:0]            col_cur;
    logic [gncm_pkg::DIM_W-1:0] row_cur;
    logic [gncm_pkg::DIM_W-1:0] col_ext;
    logic [gncm_pkg::DIM_W-1:0] col_inc;
    gncm_pkg::job_flags_t       flags_s0;
    logic                       occ_s0;
    logic                       accept;

    // Second stage.
    logic                       s1_valid_reg;
    logic [LA_W-1:0]            s1_addr_reg;
    logic                       s1_occ_reg;
    gncm_pkg::job_flags_t       s1_flags_reg;
    logic                       s1_adv;

    // Line stores: bit 1 is the middle line, bit 0 the upper line.
    logic [1:0]                 line_mem [LINE_DEPTH];
    logic [1:0]                 rd_data_reg;
    logic [1:0]                 fwd_data_reg;
    logic                       fwd_reg;
    logic [1:0]                 entry;
    logic [1:0]                 wr_data;

    logic [gncm_pkg::WINDOW_W-1:0] window_reg;
    logic [gncm_pkg::WINDOW_W-1:0] window_next;

    // Dimension clamping: zero is taken as one, large values as the cap.
    always_comb
    begin
        if (frame_width == '0)
            w_eff = DIM_ONE;
        else if (gncm_pkg::DIM_W'(frame_width) > W_CAP_V)
            w_eff = W_CAP_V;
        else
            w_eff = gncm_pkg::DIM_W'(frame_width);

        if (frame_height == '0)
            h_eff = DIM_ONE;
        else if (gncm_pkg::DIM_W'(frame_height) > H_CAP_V)
            h_eff = H_CAP_V;
        else
            h_eff = gncm_pkg::DIM_W'(frame_height);
    end

    assign h_p1 = h_eff + DIM_ONE;
    assign h_p2 = h_eff + DIM_TWO;

    assign s1_adv   = s1_valid_reg && !queue_full;
    assign in_ready = !s1_valid_reg || !queue_full;
    assign accept   = in_valid && in_ready;

    assign occ_s0  = !action && occupied;
    assign col_cur = frame_start ? '0 : col_reg;
    assign row_cur = frame_start ? '0 : row_reg;
    assign col_ext = gncm_pkg::DIM_W'(col_cur);
    assign col_inc = col_ext + DIM_ONE;

    // Classify the cell that is one row and one column behind the input.
    always_comb
    begin
        flags_s0.clear_total = frame_start;
        if (col_cur != '0)
        begin
            flags_s0.has_result = (row_cur != '0) && (row_cur <= h_eff);
            flags_s0.col_first  = (col_ext == DIM_ONE);
            flags_s0.col_last   = (col_ext >= w_eff);
            flags_s0.row_first  = (row_cur == DIM_ONE);
            flags_s0.row_last   = (row_cur >= h_eff);
            flags_s0.last_cell  = (row_cur == h_eff) && (col_ext == w_eff);
        end
        else
        begin
            flags_s0.has_result = (row_cur >= DIM_TWO) && (row_cur <= h_p1);
            flags_s0.col_first  = (w_eff == DIM_ONE);
            flags_s0.col_last   = 1'b1;
            flags_s0.row_first  = (row_cur == DIM_TWO);
            flags_s0.row_last   = (row_cur >= h_p1);
            flags_s0.last_cell  = (row_cur == h_p1);
        end
    end

    // Position advance; it stops two rows past the frame.
    always_comb
    begin
        col_next = col_cur;
        row_next = row_cur;
        if (row_cur < h_p2)
        begin
            if (col_inc >= w_eff)
            begin
                col_next = '0;
                row_next = row_cur + DIM_ONE;
            end
            else
            begin
                col_next = LA_W'(col_inc);
            end
        end
    end

    assign entry       = fwd_reg ? fwd_data_reg : rd_data_reg;
    assign wr_data     = {s1_occ_reg, entry[1]};
    assign window_next = {s1_occ_reg, entry[1], entry[0],
                          window_reg[gncm_pkg::WINDOW_W-1:3]};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            col_reg      <= '0;
            row_reg      <= '0;
            s1_valid_reg <= 1'b0;
            window_reg   <= '0;
        end
        else
        begin
            if (accept)
            begin
                col_reg <= col_next;
                row_reg <= row_next;
            end
            if (accept)
                s1_valid_reg <= 1'b1;
            else if (s1_adv)
                s1_valid_reg <= 1'b0;
            if (s1_adv)
                window_reg <= window_next;
        end
    end

    // Second stage payload and the read-after-write forward. A cell that
    // reads the entry written at the same edge takes the written value.
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            s1_addr_reg  <= col_cur;
            s1_occ_reg   <= occ_s0;
            s1_flags_reg <= flags_s0;
            fwd_reg      <= s1_valid_reg && (col_cur == s1_addr_reg);
            fwd_data_reg <= wr_data;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
            rd_data_reg <= line_mem[col_cur];
        if (s1_adv)
            line_mem[s1_addr_reg] <= wr_data;
    end

    assign job_valid  = s1_adv && (s1_flags_reg.has_result || s1_flags_reg.clear_total);
    assign job.window = window_next;
    assign job.flags  = s1_flags_reg;

endmodule

FILE: hdl/gncm_queue.sv
`timescale 1ns / 1ps
// ============================================================================
// gncm_queue: job queue between front end and back end
// A short first-in first-out store of jobs that lets the front end and the
// back end stall independently.
// ============================================================================
module gncm_queue (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           push,
    input  gncm_pkg::job_t push_data,
    output logic           full,
    input  logic           pop,
    output gncm_pkg::job_t pop_data,
    output logic           not_empty
);

    gncm_pkg::job_t                 store_reg [gncm_pkg::QUEUE_DEPTH];
    logic [gncm_pkg::QPTR_W-1:0]    wr_ptr_reg;
    logic [gncm_pkg::QPTR_W-1:0]    rd_ptr_reg;
    logic [gncm_pkg::QCNT_W-1:0]    count_reg;
    logic [gncm_pkg::QCNT_W-1:0]    count_next;

    localparam logic [gncm_pkg::QCNT_W-1:0] DEPTH_V =
        gncm_pkg::QCNT_W'(gncm_pkg::QUEUE_DEPTH);

    assign full      = (count_reg == DEPTH_V);
    assign not_empty = (count_reg != '0);
    assign pop_data  = store_reg[rd_ptr_reg];

    always_comb
    begin
        count_next = count_reg;
        if (push && !pop)
            count_next = count_reg + 1'b1;
        else if (pop && !push)
            count_next = count_reg - 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            if (pop)
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            count_reg <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
            store_reg[wr_ptr_reg] <= push_data;
    end

endmodule

FILE: hdl/gncm_back.sv
`timescale 1ns / 1ps
// ============================================================================
// gncm_back: neighbour count, threshold and running total
// Takes jobs from the queue, counts occupied neighbours inside the frame,
// marks sparse occupied cells, keeps the frame total and holds the result
// in the output register.
// ============================================================================
module gncm_back (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          job_valid,
    input  gncm_pkg::job_t                job,
    output logic                          job_pop,
    input  logic [gncm_pkg::LIMIT_W-1:0]  neighbour_limit,
    output logic                          out_valid,
    input  logic                          out_ready,
    output logic                          cell_occupied,
    output logic                          marked,
    output logic [gncm_pkg::COUNT_W-1:0]  neighbour_total,
    output logic [gncm_pkg::TOTAL_W-1:0]  marked_so_far,
    output logic                          last_cell
);

    logic [gncm_pkg::COUNT_W-1:0] count;
    logic                         centre;
    logic                         mark;
    logic [gncm_pkg::TOTAL_W-1:0] base_total;
    logic [gncm_pkg::TOTAL_W-1:0] total_next;
    logic [gncm_pkg::TOTAL_W-1:0] total_reg;
    logic                         out_valid_reg;
    logic                         cell_occupied_reg;
    logic                         marked_reg;
    logic [gncm_pkg::COUNT_W-1:0] neighbour_total_reg;
    logic                         last_cell_reg;

    assign job_pop = job_valid && (!out_valid_reg || out_ready);

    // Neighbours outside the frame are skipped, and so is the centre.
    always_comb
    begin
        count = '0;
        for (int k = 0; k < 3; k++)
        begin
            for (int j = 0; j < 3; j++)
            begin
                if (!(k == 1 && j == 1)
                    && !(k == 0 && job.flags.col_first)
                    && !(k == 2 && job.flags.col_last)
                    && !(j == 0 && job.flags.row_first)
                    && !(j == 2 && job.flags.row_last))
                    count = count + gncm_pkg::COUNT_W'(job.window[3 * k + j]);
            end
        end
    end

    assign centre = job.window[gncm_pkg::CENTRE_BIT];
    assign mark   = centre && (count < neighbour_limit);

    always_comb
    begin
        base_total = job.flags.clear_total ? '0 : total_reg;
        total_next = base_total;
        if (job.flags.has_result && mark && (base_total != gncm_pkg::TOTAL_MAX))
            total_next = base_total + 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
            total_reg     <= '0;
        end
        else
        begin
            if (job_pop)
            begin
                out_valid_reg <= job.flags.has_result;
                total_reg     <= total_next;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (job_pop && job.flags.has_result)
        begin
            cell_occupied_reg   <= centre;
            marked_reg          <= mark;
            neighbour_total_reg <= count;
            last_cell_reg       <= job.flags.last_cell;
        end
    end

    assign out_valid       = out_valid_reg;
    assign cell_occupied   = cell_occupied_reg;
    assign marked          = marked_reg;
    assign neighbour_total = neighbour_total_reg;
    assign marked_so_far   = total_reg;
    assign last_cell       = last_cell_reg;

endmodule

FILE: hdl/grid_neighbour_count_marker.sv
`timescale 1ns / 1ps
// ============================================================================
// grid_neighbour_count_marker: 3x3 neighbour count and sparse cell marker
// Streams a binary raster, counts occupied neighbours of each cell and marks
// occupied cells with few neighbours, keeping a running total per frame.
// ============================================================================
// Usage. Cells enter in raster order on the input channel (in_valid,
// in_ready, action, occupied, frame_start), one transaction per cell; the
// first cell of a frame carries frame_start. After the last cell, frame_width
// plus one drain transactions (action high) flush the final row. Each result
// transaction on the output channel reports the cell one row and one column
// behind the input, so the first result follows frame_width plus one cells.
// Configuration (frame_width, frame_height, neighbour_limit) is written
// through cfg_we, cfg_index and cfg_data while the block is idle.
// Throughput is one transaction per cycle on both channels unless stalled: the
// line store is read on acceptance and written as the second stage advances,
// with a forward for back to back accesses to the same column. Results are
// registered in the second stage, queue and output register. When the receiver
// stalls, the output register holds the result and a four-entry queue keeps
// taking jobs, so in_ready falls only once the queue is full. Reset clears
// the position, window, total and all valid state and restores the register
// defaults; the line stores are not cleared and need no clearing pass.
// ============================================================================
module grid_neighbour_count_marker #(
    parameter int MAX_WIDTH  = 256,
    parameter int MAX_HEIGHT = 256
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            in_valid,
    output logic                            in_ready,
    input  logic                            action,
    input  logic                            occupied,
    input  logic                            frame_start,
    output logic                            out_valid,
    input  logic                            out_ready,
    output logic                            cell_occupied,
    output logic                            marked,
    output logic [gncm_pkg::COUNT_W-1:0]    neighbour_total,
    output logic [gncm_pkg::TOTAL_W-1:0]    marked_so_far,
    output logic                            last_cell,
    input  logic                            cfg_we,
    input  logic [gncm_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [gncm_pkg::CFG_W-1:0]      cfg_data
);

    // Configuration registers.
    logic [gncm_pkg::CFG_W-1:0]   frame_width_reg;
    logic [gncm_pkg::CFG_W-1:0]   frame_height_reg;
    logic [gncm_pkg::LIMIT_W-1:0] neighbour_limit_reg;

    // Front end to queue, queue to back end.
    logic           push;
    gncm_pkg::job_t push_job;
    logic           queue_full;
    logic           pop;
    gncm_pkg::job_t pop_job;
    logic           queue_not_empty;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            frame_width_reg     <= gncm_pkg::FRAME_WIDTH_RESET;
            frame_height_reg    <= gncm_pkg::FRAME_HEIGHT_RESET;
            neighbour_limit_reg <= gncm_pkg::NEIGHBOUR_LIMIT_RESET;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                gncm_pkg::CFG_FRAME_WIDTH:     frame_width_reg     <= cfg_data;
                gncm_pkg::CFG_FRAME_HEIGHT:    frame_height_reg    <= cfg_data;
                gncm_pkg::CFG_NEIGHBOUR_LIMIT:
                    neighbour_limit_reg <= cfg_data[gncm_pkg::LIMIT_W-1:0];
                default:
                begin
                    // Writes to unused indexes are dropped.
                end
            endcase
        end
    end

    // The front end owns the raster position, the line stores and the
    // window; it produces one job per cell that reports or starts a frame.
    gncm_front #(
        .MAX_WIDTH  (MAX_WIDTH),
        .MAX_HEIGHT (MAX_HEIGHT)
    ) u_front (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_ready     (in_ready),
        .action       (action),
        .occupied     (occupied),
        .frame_start  (frame_start),
        .frame_width  (frame_width_reg),
        .frame_height (frame_height_reg),
        .job_valid    (push),
        .job          (push_job),
        .queue_full   (queue_full)
    );

    gncm_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_data (push_job),
        .full      (queue_full),
        .pop       (pop),
        .pop_data  (pop_job),
        .not_empty (queue_not_empty)
    );

    // The back end counts, thresholds and keeps the running total.
    gncm_back u_back (
        .clk             (clk),
        .rst_n           (rst_n),
        .job_valid       (queue_not_empty),
        .job             (pop_job),
        .job_pop         (pop),
        .neighbour_limit (neighbour_limit_reg),
        .out_valid       (out_valid),
        .out_ready       (out_ready),
        .cell_occupied   (cell_occupied),
        .marked          (marked),
        .neighbour_total (neighbour_total),
        .marked_so_far   (marked_so_far),
        .last_cell       (last_cell)
    );

endmodule

FILE: hdl/gncm_checker.sv
`timescale 1ns / 1ps
// ============================================================================
// gncm_checker: port level checks for the neighbour count marker
// Watches the result channel and flags results that cannot be right.
// ============================================================================
module gncm_checker (
    input logic                         clk,
    input logic                         rst_n,
    input logic                         out_valid,
    input logic                         out_ready,
    input logic                         cell_occupied,
    input logic                         marked,
    input logic [gncm_pkg::COUNT_W-1:0] neighbour_total,
    input logic [gncm_pkg::TOTAL_W-1:0] marked_so_far,
    input logic                         last_cell
);

    // A stalled result transaction stays put.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(marked_so_far)
            && $stable(neighbour_total) && $stable(last_cell))
    else $error("stalled result transaction changed");

    // Only occupied cells are marked.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && marked |-> cell_occupied)
    else $error("empty cell reported as marked");

    // A cell has at most eight neighbours.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> neighbour_total <= gncm_pkg::COUNT_W'(8))
    else $error("neighbour count above eight");

    // A marked cell is included in a nonzero total.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && marked |-> marked_so_far != '0)
    else $error("marked cell missing from running total");

    // An edge taken in reset leaves no result offered at the next edge.
    assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("result offered right after reset");

endmodule

bind grid_neighbour_count_marker gncm_checker u_gncm_checker (
    .clk             (clk),
    .rst_n           (rst_n),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .cell_occupied   (cell_occupied),
    .marked          (marked),
    .neighbour_total (neighbour_total),
    .marked_so_far   (marked_so_far),
    .last_cell       (last_cell)
);
